### rtl/fbfl_pkg.sv
package fbfl_pkg;

  localparam int unsigned Nodes   = 256;
  localparam int unsigned NodeW   = 8;
  localparam int unsigned LinkW   = NodeW + 1;
  localparam int unsigned RegionW = 16;
  localparam int unsigned ObjW    = 13;
  localparam int unsigned AlignW  = 4;
  localparam int unsigned AccW    = RegionW + 1;

  localparam logic [ObjW-1:0]   ObjMax   = ObjW'(4096);
  localparam logic [AlignW-1:0] AlignMax = AlignW'(12);
  localparam logic [NodeW-1:0]  LastNode = NodeW'(Nodes - 1);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LARGE = 2'd1,
    STAT_NO_MEM    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_REGION = 2'd0,
    CFG_OBJECT = 2'd1,
    CFG_ALIGN  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_INIT
  } state_e;

endpackage

### rtl/fixed_block_free_list_allocator.sv
// Allocate and free register their result as soon as they are accepted; a successful
// allocate first passes through the pop state for the registered link memory read.
// Initialize walks count = min(region/node, 256) nodes, one link write per cycle
// through the single write port of the link memory; the input stalls while not idle.
// Results sit in an output register; the input stalls while a result is held off.
// Reset (rst_ni low, async) empties the list, clears node size, loads default config.
module fixed_block_free_list_allocator import fbfl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [RegionW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [15:0]        request_bytes_i,
  input  logic [NodeW-1:0]   release_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [NodeW-1:0]   node_index_o,
  output logic [15:0]        byte_offset_o
);

  state_e state_q, state_d;

  logic [RegionW-1:0] region_q;
  logic [ObjW-1:0]    object_q;
  logic [AlignW-1:0]  align_q;

  logic [NodeW-1:0] top_q, top_d;
  logic             empty_q, empty_d;
  logic [ObjW-1:0]  nb_q, nb_d;
  logic [NodeW-1:0] idx_q, idx_d;
  logic [AccW-1:0]  acc_q, acc_d;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       status_q, status_d;
  logic [NodeW-1:0] node_q, node_d;
  logic [15:0]      offset_q, offset_d;

  logic             mem_we;
  logic [NodeW-1:0] mem_waddr;
  logic [LinkW-1:0] mem_wdata;
  logic [LinkW-1:0] mem_rdata;

  logic              in_xfer;
  logic [ObjW-1:0]   obj_eff;
  logic [AlignW-1:0] align_eff;
  logic [ObjW:0]     align_mask;
  logic [ObjW:0]     round_sum;
  logic [ObjW-1:0]   nb_calc;
  logic              too_large;
  logic [AccW-1:0]   acc_next;
  logic              init_exists;
  logic              init_last;
  logic [NodeW+ObjW-1:0] product;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_xfer     = in_valid_i && !in_stall_o;

  always_comb begin
    if (object_q == '0) begin
      obj_eff = ObjW'(1);
    end else if (object_q > ObjMax) begin
      obj_eff = ObjMax;
    end else begin
      obj_eff = object_q;
    end
  end

  assign align_eff  = (align_q > AlignMax) ? AlignMax : align_q;
  assign align_mask = ((ObjW+1)'(1) << align_eff) - (ObjW+1)'(1);
  assign round_sum  = {1'b0, obj_eff} + align_mask;
  assign nb_calc    = ObjW'(round_sum & ~align_mask);
  assign too_large  = request_bytes_i > {{(16-ObjW){1'b0}}, obj_eff};

  assign acc_next    = acc_q + AccW'(nb_q);
  assign init_exists = acc_q <= {1'b0, region_q};
  assign init_last   = (acc_next > {1'b0, region_q}) || (idx_q == LastNode);
  assign product     = top_q * nb_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (op_i)
            OP_ALLOC: begin
              if (!too_large && !empty_q) begin
                state_d = S_POP;
              end
            end
            OP_INIT: state_d = S_INIT;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_POP: state_d = S_IDLE;
      S_INIT: begin
        if (!init_exists || init_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    top_d       = top_q;
    empty_d     = empty_q;
    nb_d        = nb_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    node_d      = node_q;
    offset_d    = offset_q;
    mem_we      = 1'b0;
    mem_waddr   = release_index_i;
    mem_wdata   = {empty_q, top_q};
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          status_d = STAT_OK;
          node_d   = '0;
          offset_d = '0;
          case (op_i)
            OP_ALLOC: begin
              if (too_large) begin
                out_valid_d = 1'b1;
                status_d    = STAT_TOO_LARGE;
              end else if (empty_q) begin
                out_valid_d = 1'b1;
                status_d    = STAT_NO_MEM;
              end
            end
            OP_FREE: begin
              out_valid_d = 1'b1;
              mem_we      = 1'b1;
              top_d       = release_index_i;
              empty_d     = 1'b0;
            end
            OP_INIT: begin
              out_valid_d = 1'b1;
              nb_d        = nb_calc;
              top_d       = '0;
              empty_d     = 1'b1;
              idx_d       = '0;
              acc_d       = AccW'(nb_calc);
            end
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      S_POP: begin
        out_valid_d = 1'b1;
        status_d    = STAT_OK;
        node_d      = top_q;
        offset_d    = product[15:0];
        if (mem_rdata[LinkW-1]) begin
          empty_d = 1'b1;
        end else begin
          top_d = mem_rdata[NodeW-1:0];
        end
      end
      S_INIT: begin
        if (init_exists) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q;
          mem_wdata = {init_last, idx_q + NodeW'(1)};
          empty_d   = 1'b0;
          idx_d     = idx_q + NodeW'(1);
          acc_d     = acc_next;
        end
      end
      default: ;
    endcase
  end

  fbfl_ram #(
    .Width (LinkW),
    .Depth (Nodes)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (top_q),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= RegionW'(4096);
      object_q <= ObjW'(16);
      align_q  <= AlignW'(3);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_REGION: region_q <= cfg_data_i;
        CFG_OBJECT: object_q <= cfg_data_i[ObjW-1:0];
        CFG_ALIGN:  align_q  <= cfg_data_i[AlignW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      empty_q     <= 1'b1;
      nb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      empty_q     <= empty_d;
      nb_q        <= nb_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    acc_q    <= acc_d;
    status_q <= status_d;
    node_q   <= node_d;
    offset_q <= offset_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign node_index_o  = node_q;
  assign byte_offset_o = offset_q;

  a_pop_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |-> !out_valid_q)
    else $error("result slot occupied during pop");

  a_alloc_to_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && op_i == OP_ALLOC && !too_large && !empty_q |=> state_q == S_POP)
    else $error("successful allocate did not enter pop");

  a_init_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INIT && init_exists && !init_last
      |=> state_q == S_INIT && idx_q == $past(idx_q) + NodeW'(1))
    else $error("initialize walk did not advance");

  a_pop_has_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |-> !empty_q)
    else $error("pop from empty list");

endmodule

### rtl/fbfl_ram.sv
module fbfl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
